// ===== rtl/wcg_pkg.sv =====
package wcg_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_LENGTH_DEF         = 4096;
    localparam int unsigned QUARTER_TABLE_BITS_DEF = 10;

    // Register reset values
    localparam logic [2:0]  KIND_RESET   = 3'd1;
    localparam logic [12:0] LENGTH_RESET = 13'd256;
    localparam logic [31:0] STEP_RESET   = 32'd16843009;
    localparam logic [30:0] RECIP_RESET  = 31'd8388608;

    // Field widths fixed by the register map
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned MAG_W      = 16;
    localparam int unsigned WEIGHT_W   = 20;
    localparam int unsigned RECIP_W    = 31;

    // Unity in Q1.15
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // Window weights, Q20
    localparam logic [19:0] W_HAM0 = 20'd564511;
    localparam logic [19:0] W_HAM1 = 20'd484065;
    localparam logic [19:0] W_HANN = 20'd524288;
    localparam logic [19:0] W_BH0  = 20'd421706;
    localparam logic [19:0] W_BH1  = 20'd521174;
    localparam logic [19:0] W_BH2  = 20'd103725;
    localparam logic [19:0] W_BH3  = 20'd1971;

    // Constants for building the quarter-wave table
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    // Window kinds; codes without a member behave as Hamming
    typedef enum logic [2:0] {
        KIND_BH      = 3'd0,
        KIND_HAMMING = 3'd1,
        KIND_HANN    = 3'd2,
        KIND_RECT    = 3'd3,
        KIND_TRI     = 3'd4
    } kind_t;

    // Register indexes
    typedef enum logic [1:0] {
        REG_KIND   = 2'd0,
        REG_LENGTH = 2'd1,
        REG_STEP   = 2'd2,
        REG_RECIP  = 2'd3
    } reg_idx_t;

    // Control travelling with a word from the index stage
    typedef struct packed {
        logic  valid;
        logic  last;
        kind_t kind;
    } s0_ctrl_t;

    // Quarter-wave cosine entry k, Q15, via a 9-term Taylor series in Q30
    function automatic logic [15:0] cos_entry(input int unsigned k, input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned half;
        longint          sum;
        int unsigned     n;
        half = 64'd1 << (qbits - 1);
        x    = (64'(k) * HALF_PI_Q30 + half) >> qbits;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + 16384) >>> 15;
        if (sum > 32768)
            sum = 32768;
        return 16'(sum);
    endfunction

endpackage

// ===== rtl/wcg_cos_rom.sv =====
module wcg_cos_rom #(
    parameter int unsigned QUARTER_TABLE_BITS = wcg_pkg::QUARTER_TABLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [QUARTER_TABLE_BITS:0]   addr,
    output logic [wcg_pkg::MAG_W-1:0]     data
);

    localparam int unsigned SIZE = 1 << QUARTER_TABLE_BITS;

    logic [wcg_pkg::MAG_W-1:0] table_w [0:SIZE];
    logic [wcg_pkg::MAG_W-1:0] data_reg;

    // Constant quarter-wave table, 0 to pi/2 inclusive
    for (genvar k = 0; k <= SIZE; k++)
    begin : g_entry
        assign table_w[k] = wcg_pkg::cos_entry(k, QUARTER_TABLE_BITS);
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= table_w[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/wcg_index_gen.sv =====
module wcg_index_gen #(
    parameter int unsigned MAX_LENGTH = wcg_pkg::MAX_LENGTH_DEF,
    localparam int unsigned IDX_W = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1,
    localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              restart,
    input  logic [LEN_W-1:0]  eff_len,
    input  logic [31:0]       phase_step,
    input  wcg_pkg::kind_t    kind,
    input  logic              take,
    output wcg_pkg::s0_ctrl_t s0_ctrl,
    output logic [IDX_W-1:0]  s0_idx,
    output logic [31:0]       s0_phase
);

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [31:0]       phase_reg;
    logic [31:0]       phase_next;
    logic [IDX_W-1:0]  cur_idx;
    logic [31:0]       cur_phase;
    logic              cur_last;
    logic              en0;
    logic              accept;
    logic              s0_valid_reg;
    logic              s0_last_reg;
    wcg_pkg::kind_t    s0_kind_reg;
    logic [IDX_W-1:0]  s0_idx_reg;
    logic [31:0]       s0_phase_reg;

    assign en0       = !s0_valid_reg || take;
    assign accept    = req_valid && en0;
    assign req_stall = !en0;

    // Restart, or an index left beyond a shortened window, starts from zero
    always_comb
    begin
        if (restart || (LEN_W'(idx_reg) >= eff_len))
        begin
            cur_idx   = '0;
            cur_phase = '0;
        end
        else
        begin
            cur_idx   = idx_reg;
            cur_phase = phase_reg;
        end
        cur_last = (LEN_W'(cur_idx) == (eff_len - LEN_W'(1)));
        if (cur_last)
        begin
            idx_next   = '0;
            phase_next = '0;
        end
        else
        begin
            idx_next   = cur_idx + IDX_W'(1);
            phase_next = cur_phase + phase_step;
        end
    end

    // Running counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            phase_reg <= '0;
        end
        else if (accept)
        begin
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    // Input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en0)
            s0_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_last_reg  <= cur_last;
            s0_kind_reg  <= kind;
            s0_idx_reg   <= cur_idx;
            s0_phase_reg <= cur_phase;
        end
    end

    always_comb
    begin
        s0_ctrl.valid = s0_valid_reg;
        s0_ctrl.last  = s0_last_reg;
        s0_ctrl.kind  = s0_kind_reg;
    end

    assign s0_idx   = s0_idx_reg;
    assign s0_phase = s0_phase_reg;

    // A restart word always carries index zero
    a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> (s0_idx_reg == '0 && s0_phase_reg == '0))
        else $error("restart word did not start at index zero");

    // The counter stays inside the window after every word
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (LEN_W'(idx_reg) < eff_len))
        else $error("index counter left the window");

endmodule

// ===== rtl/wcg_coef_pipe.sv =====
module wcg_coef_pipe #(
    parameter int unsigned MAX_LENGTH         = wcg_pkg::MAX_LENGTH_DEF,
    parameter int unsigned QUARTER_TABLE_BITS = wcg_pkg::QUARTER_TABLE_BITS_DEF,
    localparam int unsigned IDX_W = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1,
    localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wcg_pkg::s0_ctrl_t             s0_ctrl,
    input  logic [IDX_W-1:0]              s0_idx,
    input  logic [31:0]                   s0_phase,
    input  logic [LEN_W-1:0]              eff_len,
    input  logic [wcg_pkg::RECIP_W-1:0]   tri_recip,
    output logic                          take,
    output logic                          coef_valid,
    input  logic                          coef_stall,
    output logic [wcg_pkg::COEF_W-1:0]    coefficient,
    output logic [IDX_W-1:0]              position,
    output logic                          last
);

    localparam int unsigned Q      = QUARTER_TABLE_BITS;
    localparam int unsigned D_W    = LEN_W + 1;
    localparam int unsigned TP_W   = D_W + wcg_pkg::RECIP_W;
    localparam int unsigned CS_W   = wcg_pkg::MAG_W + 1;
    localparam int unsigned WS_W   = wcg_pkg::WEIGHT_W + 1;
    localparam int unsigned P_W    = CS_W + WS_W;
    localparam int unsigned ACC_W  = P_W + 2;
    localparam logic [30:0] RND    = 31'(1) << (29 - Q);
    localparam logic [Q:0]  QSIZE  = (Q + 1)'(1) << Q;
    localparam int unsigned NH     = 3;

    // Stage enables: a stage moves when it is empty or the next one moves
    logic en1;
    logic en2;
    logic en3;

    // Stage 1: table addresses and lookups
    logic [31:0]              hph    [NH];
    logic [30:0]              off_sum[NH];
    logic [Q:0]               off    [NH];
    logic [Q:0]               addr   [NH];
    logic                     neg    [NH];
    logic [wcg_pkg::MAG_W-1:0] mag   [NH];
    logic [D_W-1:0]           a_dbl;
    logic [D_W-1:0]           b_end;
    logic [D_W-1:0]           d_val;

    logic                     v1_reg;
    logic                     last1_reg;
    wcg_pkg::kind_t           kind1_reg;
    logic [IDX_W-1:0]         idx1_reg;
    logic                     neg1_reg [NH];
    logic [D_W-1:0]           d1_reg;

    // Stage 2: weighted harmonics and triangular product
    logic signed [CS_W-1:0]   cs  [NH];
    logic signed [WS_W-1:0]   ws  [NH];
    logic signed [P_W-1:0]    prod[NH];
    logic [TP_W-1:0]          tri_prod;

    logic                     v2_reg;
    logic                     last2_reg;
    wcg_pkg::kind_t           kind2_reg;
    logic [IDX_W-1:0]         idx2_reg;
    logic signed [P_W-1:0]    t_reg [NH];
    logic [TP_W-1:0]          tri_reg;

    // Stage 3: sum, round and clamp
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rnd_acc;
    logic [TP_W-1:0]          drop;
    logic [wcg_pkg::COEF_W-1:0] coef_next;

    logic                     v3_reg;
    logic [wcg_pkg::COEF_W-1:0] coef_reg;
    logic [IDX_W-1:0]         pos_reg;
    logic                     last3_reg;

    assign en3  = !v3_reg || !coef_stall;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;
    assign take = en1;

    // Harmonic phases wrap modulo one turn
    assign hph[0] = s0_phase;
    assign hph[1] = s0_phase << 1;
    assign hph[2] = s0_phase + (s0_phase << 1);

    // Quadrant fold and round to the table grid
    always_comb
    begin
        for (int h = 0; h < NH; h++)
        begin
            off_sum[h] = 31'(hph[h][29:0]) + RND;
            off[h]     = off_sum[h][30:30-Q];
            addr[h]    = hph[h][30] ? (QSIZE - off[h]) : off[h];
            neg[h]     = hph[h][31] ^ hph[h][30];
        end
    end

    for (genvar h = 0; h < NH; h++)
    begin : g_rom
        wcg_cos_rom #(
            .QUARTER_TABLE_BITS(QUARTER_TABLE_BITS)
        ) u_rom (
            .clk  (clk),
            .en   (en1),
            .addr (addr[h]),
            .data (mag[h])
        );
    end

    // Triangular distance |2i - (N-1)|
    always_comb
    begin
        a_dbl = D_W'(s0_idx) << 1;
        b_end = D_W'(eff_len - LEN_W'(1));
        d_val = (a_dbl > b_end) ? (a_dbl - b_end) : (b_end - a_dbl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s0_ctrl.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            last1_reg <= s0_ctrl.last;
            kind1_reg <= s0_ctrl.kind;
            idx1_reg  <= s0_idx;
            d1_reg    <= d_val;
            for (int h = 0; h < NH; h++)
                neg1_reg[h] <= neg[h];
        end
    end

    // Signed cosines and per-kind weights
    always_comb
    begin
        for (int h = 0; h < NH; h++)
        begin
            if (neg1_reg[h])
                cs[h] = -$signed({1'b0, mag[h]});
            else
                cs[h] = $signed({1'b0, mag[h]});
        end
        case (kind1_reg)
            wcg_pkg::KIND_BH:
            begin
                ws[0] = $signed({1'b0, wcg_pkg::W_BH1});
                ws[1] = $signed({1'b0, wcg_pkg::W_BH2});
                ws[2] = $signed({1'b0, wcg_pkg::W_BH3});
            end
            wcg_pkg::KIND_HANN:
            begin
                ws[0] = $signed({1'b0, wcg_pkg::W_HANN});
                ws[1] = '0;
                ws[2] = '0;
            end
            default:
            begin
                ws[0] = $signed({1'b0, wcg_pkg::W_HAM1});
                ws[1] = '0;
                ws[2] = '0;
            end
        endcase
        for (int h = 0; h < NH; h++)
            prod[h] = P_W'(ws[h]) * P_W'(cs[h]);
        tri_prod = TP_W'(d1_reg) * TP_W'(tri_recip);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            last2_reg <= last1_reg;
            kind2_reg <= kind1_reg;
            idx2_reg  <= idx1_reg;
            tri_reg   <= tri_prod;
            for (int h = 0; h < NH; h++)
                t_reg[h] <= prod[h];
        end
    end

    // Final sum in Q35, rounded to Q15
    always_comb
    begin
        case (kind2_reg)
            wcg_pkg::KIND_BH:   base = ACC_W'($signed({1'b0, wcg_pkg::W_BH0})) <<< 15;
            wcg_pkg::KIND_HANN: base = ACC_W'($signed({1'b0, wcg_pkg::W_HANN})) <<< 15;
            default:            base = ACC_W'($signed({1'b0, wcg_pkg::W_HAM0})) <<< 15;
        endcase
        acc = base - ACC_W'(t_reg[0]) + ACC_W'(t_reg[1]) - ACC_W'(t_reg[2]);
        rnd_acc = (acc + ACC_W'(1 << 19)) >>> 20;
        drop = (tri_reg + TP_W'(32768)) >> 16;
        case (kind2_reg)
            wcg_pkg::KIND_RECT:
                coef_next = wcg_pkg::ONE_Q15;
            wcg_pkg::KIND_TRI:
            begin
                if (drop >= TP_W'(32768))
                    coef_next = '0;
                else
                    coef_next = wcg_pkg::ONE_Q15 - drop[15:0];
            end
            default:
            begin
                if (acc[ACC_W-1])
                    coef_next = '0;
                else if (rnd_acc > ACC_W'(32768))
                    coef_next = wcg_pkg::ONE_Q15;
                else
                    coef_next = rnd_acc[wcg_pkg::COEF_W-1:0];
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            coef_reg  <= coef_next;
            pos_reg   <= idx2_reg;
            last3_reg <= last2_reg;
        end
    end

    assign coef_valid  = v3_reg;
    assign coefficient = coef_reg;
    assign position    = pos_reg;
    assign last        = last3_reg;

endmodule

// ===== rtl/window_coefficient_generator.sv =====
// Window coefficient generator. Every request word yields the next coefficient
// of a window of window_length points (clamped to 2..MAX_LENGTH), unsigned Q1.15
// with 32768 as unity, together with its position and a last flag on the final
// point; the index then wraps to zero, and restart forces index zero. Kinds are
// 4-term Blackman-Harris, Hamming, Hann, rectangular and triangular; unused kind
// codes give Hamming. Cosines come from a running 32-bit phase advanced by
// phase_step and three copies of a quarter-wave table of 2^QUARTER_TABLE_BITS+1
// entries, one per harmonic. One word is taken every cycle unless req_stall is
// high; a request loads the index stage, and its coefficient then passes the
// table read, weight multiply, and sum and round stages. Up to four words wait
// in the stage registers while the output is stalled, and a stalled pipe still
// takes a request in the cycle its result leaves. Registers are to be written only
// while no word is in flight; the block itself does not enforce this.
module window_coefficient_generator #(
    parameter int unsigned MAX_LENGTH         = wcg_pkg::MAX_LENGTH_DEF,
    parameter int unsigned QUARTER_TABLE_BITS = wcg_pkg::QUARTER_TABLE_BITS_DEF,
    localparam int unsigned IDX_W = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [wcg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            restart,
    output logic                            coef_valid,
    input  logic                            coef_stall,
    output logic [wcg_pkg::COEF_W-1:0]      coefficient,
    output logic [IDX_W-1:0]                position,
    output logic                            last
);

    localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);

    wcg_pkg::kind_t              kind_reg;
    logic [12:0]                 length_reg;
    logic [31:0]                 step_reg;
    logic [wcg_pkg::RECIP_W-1:0] recip_reg;
    logic [31:0]                 len_wide;
    logic [31:0]                 len_clamped;
    logic [LEN_W-1:0]            eff_len;
    wcg_pkg::s0_ctrl_t           s0_ctrl;
    logic [IDX_W-1:0]            s0_idx;
    logic [31:0]                 s0_phase;
    logic                        take;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= wcg_pkg::kind_t'(wcg_pkg::KIND_RESET);
            length_reg <= wcg_pkg::LENGTH_RESET;
            step_reg   <= wcg_pkg::STEP_RESET;
            recip_reg  <= wcg_pkg::RECIP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wcg_pkg::REG_KIND:   kind_reg   <= wcg_pkg::kind_t'(cfg_data[2:0]);
                wcg_pkg::REG_LENGTH: length_reg <= cfg_data[12:0];
                wcg_pkg::REG_STEP:   step_reg   <= cfg_data[31:0];
                wcg_pkg::REG_RECIP:  recip_reg  <= cfg_data[wcg_pkg::RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length, clamped to the supported range
    always_comb
    begin
        len_wide = 32'(length_reg);
        if (len_wide < 32'd2)
            len_clamped = 32'd2;
        else if (len_wide > 32'(MAX_LENGTH))
            len_clamped = 32'(MAX_LENGTH);
        else
            len_clamped = len_wide;
        eff_len = len_clamped[LEN_W-1:0];
    end

    wcg_index_gen #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_index_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .restart    (restart),
        .eff_len    (eff_len),
        .phase_step (step_reg),
        .kind       (kind_reg),
        .take       (take),
        .s0_ctrl    (s0_ctrl),
        .s0_idx     (s0_idx),
        .s0_phase   (s0_phase)
    );

    wcg_coef_pipe #(
        .MAX_LENGTH         (MAX_LENGTH),
        .QUARTER_TABLE_BITS (QUARTER_TABLE_BITS)
    ) u_coef_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .s0_ctrl     (s0_ctrl),
        .s0_idx      (s0_idx),
        .s0_phase    (s0_phase),
        .eff_len     (eff_len),
        .tri_recip   (recip_reg),
        .take        (take),
        .coef_valid  (coef_valid),
        .coef_stall  (coef_stall),
        .coefficient (coefficient),
        .position    (position),
        .last        (last)
    );

    // Coefficients never exceed unity
    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid |-> (coefficient <= wcg_pkg::ONE_Q15))
        else $error("coefficient above unity");

    // The last word sits at the final point of the window
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (coef_valid && last) |-> ((LEN_W'(position) + LEN_W'(1)) == eff_len))
        else $error("last flag off the final point");

    // A rectangular window is flat
    a_rect_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (coef_valid && kind_reg == wcg_pkg::KIND_RECT) |-> (coefficient == wcg_pkg::ONE_Q15))
        else $error("rectangular window not at unity");

endmodule
